[sv/ftcl_pkg.sv]
// Shared constants and types for the FIFO tag cache lookup block.
package ftcl_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int TAG_W       = 16;
  localparam int SLOT_W      = 3;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EFF_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (EFF_W > CNT_W) ? EFF_W : CNT_W;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [TAG_W-1:0] EMPTY_TAG          = '0;
  localparam logic [CNT_W-1:0] ACTIVE_RESET       = 4'd8;
  localparam logic             REG_ACTIVE_ENTRIES = 1'b0;

  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic req;
    logic active;
    logic last;
    logic evict;
  } cell_ctl_t;

  typedef struct packed {
    logic stop;
    logic hit;
  } cell_stat_t;

endpackage

[sv/fifo_tag_cache_lookup.sv]
// Top level of the FIFO tag cache lookup block.
//
// Fully associative tag cache with first-in first-out replacement, built as a
// row of slot cells. An item is taken at a rising edge with start high and
// busy low; busy stays low, so an item may follow in every cycle. Each cell
// compares its tag with item_id and the first active cell that matches or is
// empty stops the search along the row; on a miss with no empty slot every
// active cell takes its right neighbour's tag and the last one takes item_id.
// The result appears in the cycle after acceptance, held for exactly one cycle
// with done high; the receiver cannot stall it. Throughput is one item per
// cycle. active_entries must be written through the APB port (byte address 0)
// only while the block is idle, which the block does not enforce; 0 acts as 1
// and values above the built depth act as it. Reset empties every slot, sets
// active_entries to 8 and clears done.
module fifo_tag_cache_lookup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  item_id,
  output logic                         done,
  output logic                         ignored,
  output logic                         hit,
  output logic [2:0]                   slot,
  output logic                         evicted,
  output logic [15:0]                  evicted_id,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ftcl_pkg::PADDR_W-1:0] paddr,
  input  logic [ftcl_pkg::PDATA_W-1:0] pwdata,
  output logic [ftcl_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import ftcl_pkg::*;

  logic [CNT_W-1:0]  active_entries;
  logic [EFF_W-1:0]  n_eff;
  logic              accept;
  logic              req;
  logic              evict;
  logic [IDX_W-1:0]  where_idx;
  logic              any_hit;

  logic [MAX_ENTRIES:0]        found;
  tag_t                        tags  [MAX_ENTRIES];
  tag_t                        right [MAX_ENTRIES];
  cell_ctl_t                   ctl   [MAX_ENTRIES];
  cell_stat_t                  stat  [MAX_ENTRIES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign req    = accept & (item_id != EMPTY_TAG);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1] == REG_ACTIVE_ENTRIES) begin
      active_entries <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1] == REG_ACTIVE_ENTRIES) begin
      prdata = PDATA_W'(active_entries);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    priority if (active_entries == '0) begin
      n_eff = EFF_W'(1);
    end else if (CMP_W'(active_entries) > CMP_W'(MAX_ENTRIES)) begin
      n_eff = EFF_W'(MAX_ENTRIES);
    end else begin
      n_eff = EFF_W'(active_entries);
    end
  end

  assign found[0] = 1'b0;
  assign evict    = req & ~found[MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == MAX_ENTRIES - 1) begin : g_end
      assign right[i] = EMPTY_TAG;
    end else begin : g_mid
      assign right[i] = tags[i+1];
    end

    assign ctl[i].req    = req;
    assign ctl[i].active = (EFF_W'(i) < n_eff);
    assign ctl[i].last   = (EFF_W'(i + 1) == n_eff);
    assign ctl[i].evict  = evict;

    ftcl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .item_id   (item_id),
      .found_in  (found[i]),
      .right_tag (right[i]),
      .found_out (found[i+1]),
      .stat      (stat[i]),
      .tag       (tags[i])
    );
  end

  always_comb begin
    where_idx = '0;
    any_hit   = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (stat[i].stop) begin
        where_idx = where_idx | IDX_W'(i);
      end
      any_hit = any_hit | stat[i].hit;
    end
    if (evict) begin
      where_idx = IDX_W'(n_eff - EFF_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ignored    <= ~req;
      hit        <= req & any_hit;
      slot       <= req ? SLOT_W'(where_idx) : '0;
      evicted    <= evict;
      evicted_id <= evict ? tags[0] : EMPTY_TAG;
    end
  end

endmodule

[sv/ftcl_cell.sv]
// One slot of the tag chain: holds a tag, compares it and shifts towards slot 0.
module ftcl_cell (
  input  logic              clk,
  input  logic              rst,
  input  ftcl_pkg::cell_ctl_t ctl,
  input  ftcl_pkg::tag_t    item_id,
  input  logic              found_in,
  input  ftcl_pkg::tag_t    right_tag,
  output logic              found_out,
  output ftcl_pkg::cell_stat_t stat,
  output ftcl_pkg::tag_t    tag
);
  import ftcl_pkg::*;

  logic match;
  logic empty;

  always_comb begin
    match     = (tag == item_id);
    empty     = (tag == EMPTY_TAG);
    stat.stop = ctl.active & ~found_in & (match | empty);
    stat.hit  = stat.stop & match;
    found_out = found_in | stat.stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= EMPTY_TAG;
    end else if (ctl.req && ctl.active) begin
      priority if (ctl.evict && !ctl.last) begin
        tag <= right_tag;
      end else if ((ctl.evict && ctl.last) || (stat.stop && !match)) begin
        tag <= item_id;
      end else begin
        tag <= tag;
      end
    end
  end

endmodule

[sv/ftcl_checker.sv]
// Port-level checks for the FIFO tag cache lookup block, bound to the top level.
module ftcl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [15:0]                  item_id,
  input logic                         done,
  input logic                         ignored,
  input logic                         hit,
  input logic [2:0]                   slot,
  input logic                         evicted,
  input logic [15:0]                  evicted_id
);
  import ftcl_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !rst) |=> done)
    else $error("no result after an accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted item");

  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !rst && item_id == EMPTY_TAG) |=>
      (ignored && !hit && !evicted && slot == '0 && evicted_id == EMPTY_TAG))
    else $error("empty marker item produced a non-idle result");

  a_evict_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted) && (evicted || evicted_id == EMPTY_TAG))
    else $error("inconsistent hit or eviction fields");

endmodule

bind fifo_tag_cache_lookup ftcl_checker u_ftcl_checker (.*);

[tb/tb_fifo_tag_cache_lookup.sv]
// Self-checking testbench for the FIFO tag cache lookup block.
`timescale 1ns / 1ps

module tb_fifo_tag_cache_lookup;
  import ftcl_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int POOL_SIZE       = 24;
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_ENTRIES = PADDR_W'(4 * REG_ACTIVE_ENTRIES);
  localparam logic [PADDR_W-1:0] ADDR_UNUSED         = PADDR_W'(4 * (REG_ACTIVE_ENTRIES + 1));

  typedef struct packed {
    logic              ignored;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    tag_t              evicted_id;
  } lookup_t;

  class tag_cache_tracker;
    tag_t             tags[MAX_ENTRIES];
    logic [CNT_W-1:0] active;
    lookup_t          lookup_q[$];
    int               failures;

    function new();
      foreach (tags[i]) tags[i] = EMPTY_TAG;
      active   = ACTIVE_RESET;
      failures = 0;
    endfunction

    function void write_reg(int index, logic [PDATA_W-1:0] value);
      if (index == int'(REG_ACTIVE_ENTRIES)) active = value[CNT_W-1:0];
    endfunction

    function int span();
      int n;
      n = int'(active);
      if (n < 1) n = 1;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      return n;
    endfunction

    function void note_request(tag_t id);
      lookup_t r;
      int      n;
      int      where;
      bit      found;
      bit      room;
      r     = '0;
      n     = span();
      where = 0;
      found = 0;
      room  = 0;
      if (id == EMPTY_TAG) begin
        r.ignored = 1'b1;
        lookup_q.push_back(r);
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (tags[i] == id) begin
          found = 1;
          where = i;
          break;
        end
        if (tags[i] == EMPTY_TAG) begin
          room  = 1;
          where = i;
          break;
        end
      end
      if (!found) begin
        if (!room) begin
          r.evicted    = 1'b1;
          r.evicted_id = tags[0];
          for (int i = 0; i + 1 < n; i++) tags[i] = tags[i + 1];
          where = n - 1;
        end
        tags[where] = id;
      end
      r.hit  = found;
      r.slot = SLOT_W'(where);
      lookup_q.push_back(r);
    endfunction

    function void mismatch(string what, longint unsigned expv, longint unsigned actv);
      failures++;
      if (failures <= 10) $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, expv, actv);
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (lookup_q.size() == 0) begin
        mismatch("unexpected item", 64'(0), 64'(got));
        return;
      end
      want = lookup_q.pop_front();
      if (got.ignored !== want.ignored)
        mismatch("ignored", 64'(want.ignored), 64'(got.ignored));
      if (got.hit !== want.hit) mismatch("hit", 64'(want.hit), 64'(got.hit));
      if (got.slot !== want.slot) mismatch("slot", 64'(want.slot), 64'(got.slot));
      if (got.evicted !== want.evicted)
        mismatch("evicted", 64'(want.evicted), 64'(got.evicted));
      if (got.evicted_id !== want.evicted_id)
        mismatch("evicted_id", 64'(want.evicted_id), 64'(got.evicted_id));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [15:0]        item_id;
  logic               done;
  logic               ignored;
  logic               hit;
  logic [2:0]         slot;
  logic               evicted;
  logic [15:0]        evicted_id;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tag_cache_tracker tracker = new();
  tag_t             pool[POOL_SIZE];
  int               idle_pct;
  int               stall_cycles = 0;

  fifo_tag_cache_lookup DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item_id    (item_id),
    .done       (done),
    .ignored    (ignored),
    .hit        (hit),
    .slot       (slot),
    .evicted    (evicted),
    .evicted_id (evicted_id),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_lookup(lookup_t'{ignored, hit, slot, evicted, evicted_id});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("fifo_tag_cache_lookup regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(tag_t id);
    start   = 1'b1;
    item_id = id;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(id);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start   = 1'b0;
      item_id = 16'($urandom);
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    start   = 1'b0;
    item_id = 16'($urandom);
    while (tracker.lookup_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(int'(addr >> 2), data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_active_reg();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_ACTIVE_ENTRIES;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== tracker.active)
      tracker.mismatch("active_entries readback", 64'(tracker.active),
                       64'(prdata[CNT_W-1:0]));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_active(int value);
    apb_write(ADDR_ACTIVE_ENTRIES, ($urandom & ~32'hF) | PDATA_W'(value));
    check_active_reg();
  endtask

  function automatic tag_t pick_id();
    int r;
    int top;
    r   = $urandom_range(0, 99);
    top = 2 * tracker.span() + 1;
    if (top > POOL_SIZE - 1) top = POOL_SIZE - 1;
    if (r < 4) return EMPTY_TAG;
    if (r < 14) return tag_t'($urandom_range(1, 16'hFFFF));
    if (r < 17) return 16'hFFFF;
    return pool[$urandom_range(0, top)];
  endfunction

  initial begin
    tag_t directed[15] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555,
                           16'h0002, 16'h0003, 16'h0004, 16'hFFFF, 16'h0004, 16'h1234,
                           16'h0001, 16'h0000, 16'hFFFF};
    int phase_active[PHASES] = '{8, 0, 15, 1, 3, 8, 2, 9, 5, 7, 4, 6, 8};
    rst      = 1'b1;
    start    = 1'b0;
    item_id  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    foreach (pool[i]) pool[i] = tag_t'($urandom_range(1, 16'hFFFF));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_active_reg();
    foreach (directed[i]) send_item(directed[i]);
    wait_drained();
    set_active(2);
    send_item(16'h0004);
    send_item(16'h4321);
    send_item(16'h8000);
    wait_drained();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    check_active_reg();

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      set_active(phase_active[p]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 83;
        default: idle_pct = 16;
      endcase
      repeat (ITEMS_PER_PHASE) send_item(pick_id());
    end

    start = 1'b0;
    while (tracker.lookup_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.failures == 0 && tracker.lookup_q.size() == 0) begin
      $display("fifo_tag_cache_lookup regression: pass");
    end else begin
      $display("fifo_tag_cache_lookup regression: fail");
    end
    $finish;
  end

endmodule
